@@ hw/rtl/hcbd_pkg.sv @@
// package: types, constants and helpers for the chunked body decoder
`default_nettype none

package hcbd_pkg;

  // width of the chunk size accumulator and byte counter
  localparam int unsigned SIZE_BITS = 32;

  // characters the decoder looks at
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;

  // decoder phase
  typedef enum logic [2:0] {
    PH_SIZE     = 3'd0,
    PH_EXT      = 3'd1,
    PH_DATA     = 3'd2,
    PH_EXPCR    = 3'd3,
    PH_EXPLF    = 3'd4,
    PH_TRAILER  = 3'd5,
    PH_COMPLETE = 3'd6,
    PH_ERROR    = 3'd7
  } phase_e;

  // error codes reported on the detecting beat
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_NO_CRLF  = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  // one result beat
  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    logic       chunk_last;
    logic       message_done;
    err_e       error_code;
  } hcbd_res_t;

  // hex character decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    logic [7:0] t;
    r = 5'd0;
    t = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
      r = {1'b1, t[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
      r = {1'b1, t[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
      r = {1'b1, t[3:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hcbd_stream_if.sv @@
// stream interfaces for the input and result channels of the decoder
`default_nettype none

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       body_valid;
  logic       chunk_last;
  logic       message_done;
  logic [1:0] error_code;

  modport source (output valid, output body_byte, output body_valid, output chunk_last,
                  output message_done, output error_code, input ready);
  modport sink   (input valid, input body_byte, input body_valid, input chunk_last,
                  input message_done, input error_code, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hcbd_core.sv @@
// decoder state and per-beat step logic
`default_nettype none

module hcbd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               kind_i,
  input  logic [7:0]         data_byte_i,
  output hcbd_pkg::hcbd_res_t res_o,
  output hcbd_pkg::phase_e   phase_o
);
  import hcbd_pkg::*;

  phase_e                phase_q, phase_d;
  logic [SIZE_BITS-1:0]  acc_q, acc_d;
  logic [SIZE_BITS-1:0]  left_q, left_d;
  logic [SIZE_BITS-1:0]  left_dec;
  logic                  cr_q, cr_d;
  logic                  bad_q, bad_d;
  logic                  empty_q, empty_d;
  logic                  ovf_q, ovf_d;
  logic [4:0]            hex;
  hcbd_res_t             res;

  assign hex      = hex_digit(data_byte_i);
  assign left_dec = left_q - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  // next state and result for the current beat
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    left_d  = left_q;
    cr_d    = cr_q;
    bad_d   = bad_q;
    empty_d = empty_q;
    ovf_d   = ovf_q;
    res     = '0;
    if (kind_i) begin
      // start beat re-arms everything
      phase_d = PH_SIZE;
      left_d  = '0;
      acc_d   = '0;
      cr_d    = 1'b0;
      bad_d   = 1'b0;
      empty_d = 1'b1;
      ovf_d   = 1'b0;
    end else begin
      case (phase_q)
        PH_SIZE, PH_EXT: begin
          if (cr_q && data_byte_i == CH_LF) begin
            // end of size line
            if (bad_q) begin
              res.error_code = ERR_BAD_CHAR;
              phase_d        = PH_ERROR;
            end else if (ovf_q) begin
              res.error_code = ERR_OVERFLOW;
              phase_d        = PH_ERROR;
            end else if (acc_q == '0) begin
              phase_d = PH_TRAILER;
            end else begin
              left_d  = acc_q;
              phase_d = PH_DATA;
            end
            acc_d   = '0;
            cr_d    = 1'b0;
            bad_d   = 1'b0;
            empty_d = 1'b1;
            ovf_d   = 1'b0;
          end else begin
            // lone cr is an ordinary character
            if (cr_q) begin
              cr_d = 1'b0;
              if (phase_q == PH_SIZE) begin
                bad_d = 1'b1;
              end
            end
            if (data_byte_i == CH_CR) begin
              cr_d = 1'b1;
            end else if (phase_q == PH_EXT) begin
              // extension text ignored
            end else if (data_byte_i == CH_SEMI) begin
              phase_d = PH_EXT;
            end else if (data_byte_i == CH_SP || data_byte_i == CH_TAB) begin
              // whitespace skipped
            end else if (hex[4]) begin
              if (acc_q[SIZE_BITS-1 -: 4] != 4'd0) begin
                ovf_d = 1'b1;
              end
              acc_d = {acc_q[SIZE_BITS-5:0], hex[3:0]};
            end else begin
              bad_d = 1'b1;
            end
          end
        end
        PH_DATA: begin
          res.body_byte  = data_byte_i;
          res.body_valid = 1'b1;
          left_d         = left_dec;
          if (left_dec == '0) begin
            res.chunk_last = 1'b1;
            phase_d        = PH_EXPCR;
          end
        end
        PH_EXPCR: begin
          if (data_byte_i == CH_CR) begin
            phase_d = PH_EXPLF;
          end else begin
            res.error_code = ERR_NO_CRLF;
            phase_d        = PH_ERROR;
          end
        end
        PH_EXPLF: begin
          if (data_byte_i == CH_LF) begin
            phase_d = PH_SIZE;
            acc_d   = '0;
            cr_d    = 1'b0;
            bad_d   = 1'b0;
            empty_d = 1'b1;
            ovf_d   = 1'b0;
          end else begin
            res.error_code = ERR_NO_CRLF;
            phase_d        = PH_ERROR;
          end
        end
        PH_TRAILER: begin
          if (cr_q && data_byte_i == CH_LF) begin
            if (empty_q) begin
              res.message_done = 1'b1;
              phase_d          = PH_COMPLETE;
            end
            acc_d   = '0;
            cr_d    = 1'b0;
            bad_d   = 1'b0;
            empty_d = 1'b1;
            ovf_d   = 1'b0;
          end else begin
            if (cr_q) begin
              cr_d    = 1'b0;
              empty_d = 1'b0;
            end
            if (data_byte_i == CH_CR) begin
              cr_d = 1'b1;
            end else begin
              empty_d = 1'b0;
            end
          end
        end
        default: begin
          // complete or error: beats ignored
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COMPLETE;
      acc_q   <= '0;
      left_q  <= '0;
      cr_q    <= 1'b0;
      bad_q   <= 1'b0;
      empty_q <= 1'b1;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      cr_q    <= cr_d;
      bad_q   <= bad_d;
      empty_q <= empty_d;
      ovf_q   <= ovf_d;
    end
  end

  assign res_o   = res;
  assign phase_o = phase_q;

endmodule

`default_nettype wire

@@ hw/rtl/http_chunked_body_decoder.sv @@
// top level of the chunked http/1.1 body decoder
//
//   channel  dir  modport  payload
//   in_i     in   sink     kind, data_byte
//   out_o    out  source   body_byte, body_valid, chunk_last, message_done, error_code
//
// one result beat per input beat, passed from the input register
// through the step logic into the result register
// a new beat can be taken every cycle unless out_o stalls; the result register frees as out_o.ready takes it
// a stall on out_o holds both registers and backs up into in_i.ready
// reset leaves the decoder waiting for a start beat; no clearing pass
`default_nettype none

module http_chunked_body_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbd_in_if.sink    in_i,
  hcbd_out_if.source out_o
);
  import hcbd_pkg::*;

  logic       in_valid_q;
  logic       kind_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  hcbd_res_t  res_q;
  hcbd_res_t  res;
  phase_e     phase;
  logic       advance;

  // step when the input stage holds a beat and the result stage has room
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= in_i.kind;
      byte_q <= in_i.data_byte;
    end
  end

  hcbd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .kind_i      (kind_q),
    .data_byte_i (byte_q),
    .res_o       (res),
    .phase_o     (phase)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.body_byte    = res_q.body_byte;
  assign out_o.body_valid   = res_q.body_valid;
  assign out_o.chunk_last   = res_q.chunk_last;
  assign out_o.message_done = res_q.message_done;
  assign out_o.error_code   = res_q.error_code;

`ifndef SYNTHESIS
  // an accepted beat lands in the input stage
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> in_valid_q)
    else $error("accepted beat not captured");

  // a held input beat is never dropped
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input stage lost a beat");

  // any reported error parks the decoder in its error phase
  a_err_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.error_code != ERR_NONE |=> phase == PH_ERROR)
    else $error("error reported without entering error phase");
`endif

endmodule

`default_nettype wire

@@ sim/http_chunked_body_decoder_tb.sv @@
`timescale 1ns / 1ps
// testbench for the chunked body decoder: directed cases, then random chunked messages against a built-in decoder model

module http_chunked_body_decoder_tb;
  import hcbd_pkg::*;

  // input beat kinds
  localparam bit KIND_BYTE  = 1'b0;
  localparam bit KIND_START = 1'b1;

  localparam int RUN_BEATS    = 1400;
  localparam int RESET_CYCLES = 10;
  localparam int TAIL_CYCLES  = 8;
  // room for about 2000 beats in the worst stall mix, many times over
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SHOW_LIMIT   = 10;

  // ways a generated message is damaged
  typedef enum int {
    F_NONE, F_BAD_CHAR, F_LONE_CR, F_OVERFLOW, F_NO_CRLF, F_CUT_SHORT, F_NOISE
  } flaw_e;

  // decoder model plus the queue of result beats still owed by the block
  class chunk_decode_checker;
    phase_e               ph;
    logic [SIZE_BITS-1:0] size_acc;
    logic [SIZE_BITS-1:0] left;
    bit                   cr_seen;
    bit                   bad_char;
    bit                   blank_line;
    bit                   too_big;
    hcbd_res_t            decoded_q[$];
    int                   fails;

    function new();
      ph    = PH_COMPLETE;
      left  = '0;
      fails = 0;
      restart_line();
    endfunction

    function void restart_line();
      size_acc   = '0;
      cr_seen    = 1'b0;
      bad_char   = 1'b0;
      blank_line = 1'b1;
      too_big    = 1'b0;
    endfunction

    // size line character that is not the lf of a cr lf pair
    function void size_line_char(logic [7:0] c);
      logic [3:0] d;
      d = 4'd0;
      if (c == CH_CR) begin
        cr_seen = 1'b1;
        return;
      end
      if (ph == PH_EXT) return;
      if (c == CH_SEMI) begin
        ph = PH_EXT;
        return;
      end
      if (c == CH_SP || c == CH_TAB) return;
      if (c >= "0" && c <= "9") begin
        d = c[3:0];
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
        d = c[3:0] + 4'd9;
      end else begin
        bad_char = 1'b1;
        return;
      end
      // a digit on top of a nonzero top nibble overflows, the value wraps
      if (size_acc[SIZE_BITS-1 -: 4] != 4'd0) too_big = 1'b1;
      size_acc = {size_acc[SIZE_BITS-5:0], d};
    endfunction

    // step the model on one accepted input beat; returns 1 unless the beat is ignored
    function bit take_input_beat(bit kind, logic [7:0] c);
      hcbd_res_t r;
      bit        live;
      r    = '0;
      live = (kind == KIND_START) || (ph != PH_COMPLETE && ph != PH_ERROR);
      if (kind == KIND_START) begin
        ph   = PH_SIZE;
        left = '0;
        restart_line();
      end else begin
        case (ph)
          PH_SIZE, PH_EXT: begin
            if (cr_seen && c == CH_LF) begin
              if (bad_char) begin
                r.error_code = ERR_BAD_CHAR;
                ph = PH_ERROR;
              end else if (too_big) begin
                r.error_code = ERR_OVERFLOW;
                ph = PH_ERROR;
              end else if (size_acc == '0) begin
                ph = PH_TRAILER;
              end else begin
                left = size_acc;
                ph = PH_DATA;
              end
              restart_line();
            end else begin
              // in the size phase, a cr not followed by lf is a bad size character
              if (cr_seen) begin
                cr_seen = 1'b0;
                if (ph == PH_SIZE) bad_char = 1'b1;
              end
              size_line_char(c);
            end
          end
          PH_DATA: begin
            r.body_byte  = c;
            r.body_valid = 1'b1;
            left = left - 1'b1;
            if (left == '0) begin
              r.chunk_last = 1'b1;
              ph = PH_EXPCR;
            end
          end
          PH_EXPCR: begin
            if (c == CH_CR) begin
              ph = PH_EXPLF;
            end else begin
              r.error_code = ERR_NO_CRLF;
              ph = PH_ERROR;
            end
          end
          PH_EXPLF: begin
            if (c == CH_LF) begin
              ph = PH_SIZE;
              restart_line();
            end else begin
              r.error_code = ERR_NO_CRLF;
              ph = PH_ERROR;
            end
          end
          PH_TRAILER: begin
            if (cr_seen && c == CH_LF) begin
              if (blank_line) begin
                r.message_done = 1'b1;
                ph = PH_COMPLETE;
              end
              restart_line();
            end else begin
              if (cr_seen) begin
                cr_seen    = 1'b0;
                blank_line = 1'b0;
              end
              if (c == CH_CR) cr_seen = 1'b1;
              else blank_line = 1'b0;
            end
          end
          default: ;
        endcase
      end
      decoded_q.push_back(r);
      return live;
    endfunction

    // compare one result beat with the oldest owed one
    function void match_result_beat(hcbd_res_t got);
      hcbd_res_t want;
      if (decoded_q.size() == 0) begin
        fails++;
        if (fails <= SHOW_LIMIT)
          $display("%0t: unexpected result beat: byte %02h valid %0b last %0b done %0b err %0d",
                   $realtime, got.body_byte, got.body_valid, got.chunk_last,
                   got.message_done, got.error_code);
        return;
      end
      want = decoded_q.pop_front();
      if (got.body_byte !== want.body_byte || got.body_valid !== want.body_valid ||
          got.chunk_last !== want.chunk_last || got.message_done !== want.message_done ||
          got.error_code !== want.error_code) begin
        fails++;
        if (fails <= SHOW_LIMIT) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected byte %02h valid %0b last %0b done %0b err %0d",
                   want.body_byte, want.body_valid, want.chunk_last,
                   want.message_done, want.error_code);
          $display("  actual   byte %02h valid %0b last %0b done %0b err %0d",
                   got.body_byte, got.body_valid, got.chunk_last,
                   got.message_done, got.error_code);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hcbd_in_if  in_if ();
  hcbd_out_if out_if ();

  http_chunked_body_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  chunk_decode_checker dec_check;
  bit                  no_idle;
  bit                  drained_mid;
  int                  live_beats;
  int unsigned         cycles;

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // result side stalls
  always @(negedge clk_i) begin
    out_if.ready <= no_idle || ($urandom_range(99) >= 38);
  end

  // result beats checked at the rising edge; past the cycle limit the run ends as failed
  always @(posedge clk_i) begin : result_side
    hcbd_res_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.body_byte    = out_if.body_byte;
      got.body_valid   = out_if.body_valid;
      got.chunk_last   = out_if.chunk_last;
      got.message_done = out_if.message_done;
      got.error_code   = err_e'(out_if.error_code);
      dec_check.match_result_beat(got);
    end
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one input beat, held until taken; returns at the falling edge after the handshake
  task automatic send_beat(input bit k, input logic [7:0] b);
    if (!no_idle) begin
      while ($urandom_range(99) < 38) begin
        in_if.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= k;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    if (dec_check.take_input_beat(k, b)) live_beats++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(KIND_BYTE, s[i]);
  endtask

  task automatic send_crlf();
    send_beat(KIND_BYTE, CH_CR);
    send_beat(KIND_BYTE, CH_LF);
  endtask

  // sender stops until every owed result beat is back
  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (dec_check.decoded_q.size() != 0) @(negedge clk_i);
  endtask

  // any byte that is illegal before the semicolon of a size line
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") ||
               c == CH_SP || c == CH_TAB || c == CH_SEMI || c == CH_CR);
    return c;
  endfunction

  // text byte for extensions and trailers, never a cr
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    if ($urandom_range(99) < 80) return 8'($urandom_range(8'h21, 8'h7e));
    do c = 8'($urandom_range(255)); while (c == CH_CR);
    return c;
  endfunction

  task automatic send_blanks();
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(1, 3)) send_beat(KIND_BYTE, $urandom_range(1) ? CH_SP : CH_TAB);
  endtask

  // line text with the odd lone cr in it
  task automatic send_line_text(input int n);
    logic [7:0] c;
    repeat (n) begin
      if ($urandom_range(99) < 8) begin
        c = text_char();
        if (c == CH_LF) c = 8'h41;
        send_beat(KIND_BYTE, CH_CR);
        send_beat(KIND_BYTE, c);
      end else begin
        send_beat(KIND_BYTE, text_char());
      end
    end
  endtask

  // chunk size line, optionally damaged
  task automatic send_size_line(input logic [31:0] size, input flaw_e flaw, input bit empty_size);
    string digits;
    int    zeros;
    digits = $sformatf("%0h", size);
    if ($urandom_range(1)) digits = digits.toupper();
    if (empty_size) digits = "";
    if (flaw == F_OVERFLOW) digits = $sformatf("%0h%08h", $urandom_range(1, 255), $urandom());
    zeros = ($urandom_range(99) < 10) ? $urandom_range(1, 12) : 0;
    send_blanks();
    repeat (zeros) send_beat(KIND_BYTE, "0");
    send_text(digits);
    if (flaw == F_BAD_CHAR || (flaw == F_OVERFLOW && $urandom_range(3) == 0))
      send_beat(KIND_BYTE, junk_char());
    if (flaw == F_LONE_CR) begin
      send_beat(KIND_BYTE, CH_CR);
      case ($urandom_range(2))
        0: send_beat(KIND_BYTE, "1");
        1: send_beat(KIND_BYTE, CH_CR);
        default: send_beat(KIND_BYTE, CH_SP);
      endcase
    end
    send_blanks();
    if ($urandom_range(99) < 25) begin
      send_beat(KIND_BYTE, CH_SEMI);
      send_line_text($urandom_range(0, 6));
    end
    send_crlf();
  endtask

  // one chunked message from its start beat, with at most one flaw
  task automatic send_message(input flaw_e flaw);
    int          chunks;
    logic [31:0] size;
    bit          line_flaw;
    line_flaw = (flaw == F_BAD_CHAR || flaw == F_LONE_CR || flaw == F_OVERFLOW);
    send_beat(KIND_START, 8'($urandom_range(255)));
    if (flaw == F_NOISE) begin
      repeat ($urandom_range(3, 12)) send_beat(KIND_BYTE, 8'($urandom_range(255)));
      return;
    end
    chunks = $urandom_range(0, 3);
    if (flaw == F_NO_CRLF || flaw == F_CUT_SHORT) chunks++;
    for (int n = 0; n < chunks; n++) begin
      size = ($urandom_range(99) < 75) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      if (n == 0 && flaw == F_CUT_SHORT) begin
        if ($urandom_range(1)) begin
          // size line left open, the next start cuts it off
          send_text("1f");
          if ($urandom_range(1)) send_beat(KIND_BYTE, junk_char());
          send_beat(KIND_BYTE, CH_CR);
        end else begin
          // huge chunk, cut off after a few payload bytes
          send_size_line($urandom() | 32'h100, F_NONE, 1'b0);
          repeat ($urandom_range(0, 5)) send_beat(KIND_BYTE, 8'($urandom_range(255)));
        end
        return;
      end
      send_size_line(size, (n == 0) ? flaw : F_NONE, 1'b0);
      if (n == 0 && line_flaw) return;
      repeat (size) send_beat(KIND_BYTE, 8'($urandom_range(255)));
      if (n == 0 && flaw == F_NO_CRLF) begin
        if ($urandom_range(1)) begin
          send_beat(KIND_BYTE, text_char());
        end else begin
          send_beat(KIND_BYTE, CH_CR);
          send_beat(KIND_BYTE, $urandom_range(1) ? CH_CR : 8'h30);
        end
        return;
      end
      send_crlf();
    end
    // zero chunk, trailer lines, empty line
    send_size_line(32'd0, (chunks == 0) ? flaw : F_NONE, $urandom_range(99) < 15);
    if (chunks == 0 && line_flaw) return;
    repeat ($urandom_range(0, 2)) begin
      send_line_text($urandom_range(1, 8));
      send_crlf();
    end
    send_crlf();
  endtask

  // stimulus
  initial begin
    int    roll;
    flaw_e flaw;
    dec_check        = new();
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_BYTE;
    in_if.data_byte  = 8'h00;
    out_if.ready     = 1'b0;
    no_idle          = 1'b0;
    drained_mid      = 1'b0;
    live_beats       = 0;
    cycles           = 0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // byte before any start is ignored
    send_beat(KIND_BYTE, 8'hff);
    // two byte chunk with extreme payload values, then zero chunk and empty trailer
    send_beat(KIND_START, 8'hff);
    send_text("2");
    send_crlf();
    send_beat(KIND_BYTE, 8'h00);
    send_beat(KIND_BYTE, 8'hff);
    send_crlf();
    send_text("0");
    send_crlf();
    send_crlf();
    // bad size character, then a byte ignored after the error
    send_beat(KIND_START, 8'h00);
    send_text("g");
    send_crlf();
    send_beat(KIND_BYTE, 8'h55);
    // payload not followed by cr lf
    send_beat(KIND_START, 8'h5a);
    send_text("1");
    send_crlf();
    send_text("ZX");
    hold_until_drained();

    // random messages, mostly well formed
    while (live_beats < RUN_BEATS) begin
      no_idle <= (live_beats >= 500 && live_beats < 800);
      if (!drained_mid && live_beats >= 1000) begin
        hold_until_drained();
        drained_mid = 1'b1;
      end
      roll = $urandom_range(99);
      flaw = (roll < 70) ? F_NONE : flaw_e'($urandom_range(1, 6));
      send_message(flaw);
      // stray bytes between messages
      if ($urandom_range(99) < 10)
        repeat ($urandom_range(1, 4)) send_beat(KIND_BYTE, 8'($urandom_range(255)));
    end

    // drain and finish
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (dec_check.decoded_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    dec_check.fails += dec_check.decoded_q.size();
    if (dec_check.fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_stream_if.sv
hw/rtl/hcbd_core.sv
hw/rtl/http_chunked_body_decoder.sv
sim/http_chunked_body_decoder_tb.sv
